/* hdl/itsolv_pkg.sv */
`default_nettype none
package itsolv_pkg;

   localparam int COORD_WIDTH_DEFAULT = 24;
   localparam int INNER_WIDTH = 24;
   localparam int INNER_MAX = (1 << (INNER_WIDTH - 1)) - 1;
   localparam int SPEED_WIDTH = 23;
   localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = 23'd2560000;
   localparam int TIME_WIDTH = 24;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
   localparam int FRAC_BITS = 16;
   localparam int INT_BITS = TIME_WIDTH - FRAC_BITS;

   localparam int PROD_WIDTH = 2 * INNER_WIDTH;
   localparam int HALF_WIDTH = INNER_WIDTH;
   localparam int B_WIDTH = PROD_WIDTH + 2;
   localparam int WIDE_WIDTH = 2 * PROD_WIDTH;
   localparam int DISC_WIDTH = WIDE_WIDTH + 2;
   localparam int ROOT_WIDTH = DISC_WIDTH / 2;
   localparam int SQRT_STEPS = ROOT_WIDTH;
   localparam int SQ_REM_WIDTH = ROOT_WIDTH + 3;
   localparam int N_WIDTH = B_WIDTH + 2;
   localparam int NUM_WIDTH = PROD_WIDTH + 2;
   localparam int DIV_STEPS = TIME_WIDTH;
   localparam int TP_WIDTH = INNER_WIDTH + TIME_WIDTH + 1;

   localparam int ADDR_WIDTH = 3;
   localparam int DATA_WIDTH = 32;
   localparam logic [0:0] REG_SPEED = 1'b0;

   typedef struct packed {
      logic [2:0][INNER_WIDTH-1:0] d;
      logic [2:0][INNER_WIDTH-1:0] v;
   } geo_type;

   typedef struct packed {
      logic                       vld;
      geo_type                    geo;
      logic signed [B_WIDTH-1:0]  b;
      logic [PROD_WIDTH-1:0]      c;
      logic [PROD_WIDTH-1:0]      a_abs;
      logic [PROD_WIDTH-1:0]      b_abs;
      logic                       a_neg;
      logic                       a_zero;
   } quad_type;

   typedef struct packed {
      quad_type                  q;
      logic                      real_ok;
      logic [DISC_WIDTH-1:0]     disc;
      logic [ROOT_WIDTH-1:0]     root;
      logic [SQ_REM_WIDTH-1:0]   rem;
   } sq_type;

   typedef struct packed {
      logic                   vld;
      geo_type                geo;
      logic                   hit;
      logic                   sat;
      logic [NUM_WIDTH-1:0]   num;
      logic [NUM_WIDTH-1:0]   den;
      logic [NUM_WIDTH-1:0]   rem;
      logic [TIME_WIDTH-1:0]  quo;
   } dv_type;

endpackage
`default_nettype wire

/* hdl/itsolv_req_if.sv */
`default_nettype none
interface itsolv_req_if #(
   parameter int COORD_WIDTH = itsolv_pkg::COORD_WIDTH_DEFAULT
);
   logic                           valid;
   logic                           ready;
   logic signed [COORD_WIDTH-1:0]  rel_x;
   logic signed [COORD_WIDTH-1:0]  rel_y;
   logic signed [COORD_WIDTH-1:0]  rel_z;
   logic signed [COORD_WIDTH-1:0]  vel_x;
   logic signed [COORD_WIDTH-1:0]  vel_y;
   logic signed [COORD_WIDTH-1:0]  vel_z;

   modport source (output valid, rel_x, rel_y, rel_z, vel_x, vel_y, vel_z, input ready);
   modport sink (input valid, rel_x, rel_y, rel_z, vel_x, vel_y, vel_z, output ready);
endinterface
`default_nettype wire

/* hdl/itsolv_rsp_if.sv */
`default_nettype none
interface itsolv_rsp_if #(
   parameter int COORD_WIDTH = itsolv_pkg::COORD_WIDTH_DEFAULT
);
   logic                                   valid;
   logic                                   ready;
   logic                                   hit_valid;
   logic [itsolv_pkg::TIME_WIDTH-1:0]      hit_time;
   logic signed [COORD_WIDTH-1:0]          aim_x;
   logic signed [COORD_WIDTH-1:0]          aim_y;
   logic signed [COORD_WIDTH-1:0]          aim_z;
   logic                                   clipped;

   modport source (output valid, hit_valid, hit_time, aim_x, aim_y, aim_z, clipped,
                   input ready);
   modport sink (input valid, hit_valid, hit_time, aim_x, aim_y, aim_z, clipped,
                 output ready);
endinterface
`default_nettype wire

/* hdl/intercept_time_solver.sv */
// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds while the response register is full and not taken.
// Depth is set by the square root (49 one-bit stages) and the divider (24 stages).
// Reset (synchronous, active high) empties the pipeline and loads the default speed.
`default_nettype none
module intercept_time_solver #(
   parameter int COORD_WIDTH = itsolv_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   itsolv_req_if.sink                                req_bus,
   itsolv_rsp_if.source                              rsp_bus,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [itsolv_pkg::ADDR_WIDTH-1:0]    paddr,
   input  wire logic [itsolv_pkg::DATA_WIDTH-1:0]    pwdata,
   output logic [itsolv_pkg::DATA_WIDTH-1:0]         prdata,
   output logic                                      pready
);

   localparam int IW = itsolv_pkg::INNER_WIDTH;
   localparam int PW = itsolv_pkg::PROD_WIDTH;
   localparam int HW = itsolv_pkg::HALF_WIDTH;
   localparam int BW = itsolv_pkg::B_WIDTH;
   localparam int WW = itsolv_pkg::WIDE_WIDTH;
   localparam int DW = itsolv_pkg::DISC_WIDTH;
   localparam int RW = itsolv_pkg::ROOT_WIDTH;
   localparam int SRW = itsolv_pkg::SQ_REM_WIDTH;
   localparam int NW = itsolv_pkg::N_WIDTH;
   localparam int UW = itsolv_pkg::NUM_WIDTH;
   localparam int TW = itsolv_pkg::TIME_WIDTH;
   localparam int SW = itsolv_pkg::SPEED_WIDTH;
   localparam int FB = itsolv_pkg::FRAC_BITS;
   localparam int IB = itsolv_pkg::INT_BITS;
   localparam int PTW = itsolv_pkg::TP_WIDTH;
   localparam int SQS = itsolv_pkg::SQRT_STEPS;
   localparam int DVS = itsolv_pkg::DIV_STEPS;
   localparam int EXT_WIDTH = 33;
   localparam int SUM_WIDTH = PTW - FB + 1;
   localparam logic signed [EXT_WIDTH-1:0] IN_HI = EXT_WIDTH'(itsolv_pkg::INNER_MAX);
   localparam logic signed [EXT_WIDTH-1:0] IN_LO = -IN_HI - 1;
   localparam logic signed [SUM_WIDTH-1:0] AIM_HI =
      SUM_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SUM_WIDTH-1:0] AIM_LO = -AIM_HI - 1;

   function automatic logic [IW-1:0] sat_in(input logic [COORD_WIDTH-1:0] x);
      logic signed [EXT_WIDTH-1:0] xe;
      xe = $signed({{(EXT_WIDTH - COORD_WIDTH){x[COORD_WIDTH-1]}}, x});
      if (xe > IN_HI) begin
         return IN_HI[IW-1:0];
      end else if (xe < IN_LO) begin
         return IN_LO[IW-1:0];
      end
      return xe[IW-1:0];
   endfunction

   // configuration
   logic [SW-1:0] speed_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= itsolv_pkg::SPEED_RESET;
      end else if (psel && penable && pwrite && paddr[2:2] == itsolv_pkg::REG_SPEED) begin
         speed_ff <= pwdata[SW-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2:2] == itsolv_pkg::REG_SPEED) begin
         prdata = {{(itsolv_pkg::DATA_WIDTH - SW){1'b0}}, speed_ff};
      end
   end

   // pipeline advance
   logic out_vld_ff;
   logic adv;

   assign adv = !out_vld_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // stage 0: capture and clamp
   logic                vld0_ff;
   itsolv_pkg::geo_type geo0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (adv) begin
         vld0_ff <= req_bus.valid;
         geo0_ff.d[0] <= sat_in(req_bus.rel_x);
         geo0_ff.d[1] <= sat_in(req_bus.rel_y);
         geo0_ff.d[2] <= sat_in(req_bus.rel_z);
         geo0_ff.v[0] <= sat_in(req_bus.vel_x);
         geo0_ff.v[1] <= sat_in(req_bus.vel_y);
         geo0_ff.v[2] <= sat_in(req_bus.vel_z);
      end
   end

   // stage 1: products
   logic                    vld1_ff;
   itsolv_pkg::geo_type     geo1_ff;
   logic signed [PW-1:0]    dd1_ff [3];
   logic signed [PW-1:0]    vv1_ff [3];
   logic signed [PW-1:0]    dv1_ff [3];
   logic [2*SW-1:0]         ss1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= vld0_ff;
         geo1_ff <= geo0_ff;
         for (int i = 0; i < 3; i++) begin
            dd1_ff[i] <= $signed(geo0_ff.d[i]) * $signed(geo0_ff.d[i]);
            vv1_ff[i] <= $signed(geo0_ff.v[i]) * $signed(geo0_ff.v[i]);
            dv1_ff[i] <= $signed(geo0_ff.d[i]) * $signed(geo0_ff.v[i]);
         end
         ss1_ff <= speed_ff * speed_ff;
      end
   end

   // stage 2: coefficients
   logic                    vld2_ff;
   itsolv_pkg::geo_type     geo2_ff;
   logic signed [BW-1:0]    a2_ff;
   logic signed [BW-1:0]    b2_ff;
   logic [PW-1:0]           c2_ff;
   logic [PW-1:0]           vsum;

   assign vsum = PW'(vv1_ff[0]) + PW'(vv1_ff[1]) + PW'(vv1_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld2_ff <= vld1_ff;
         geo2_ff <= geo1_ff;
         c2_ff <= PW'(dd1_ff[0]) + PW'(dd1_ff[1]) + PW'(dd1_ff[2]);
         b2_ff <= BW'(dv1_ff[0]) + BW'(dv1_ff[1]) + BW'(dv1_ff[2]);
         a2_ff <= $signed({{(BW - PW){1'b0}}, vsum})
                  - $signed({{(BW - 2 * SW){1'b0}}, ss1_ff});
      end
   end

   // stage 3: magnitudes
   itsolv_pkg::quad_type q3_ff;
   itsolv_pkg::quad_type q3_in;
   logic signed [BW-1:0] a_mag;
   logic signed [BW-1:0] b_mag;

   always_comb begin
      a_mag = a2_ff[BW-1] ? -a2_ff : a2_ff;
      b_mag = b2_ff[BW-1] ? -b2_ff : b2_ff;
      q3_in.vld = vld2_ff;
      q3_in.geo = geo2_ff;
      q3_in.b = b2_ff;
      q3_in.c = c2_ff;
      q3_in.a_abs = a_mag[PW-1:0];
      q3_in.b_abs = b_mag[PW-1:0];
      q3_in.a_neg = a2_ff[BW-1];
      q3_in.a_zero = (a2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q3_ff.vld <= 1'b0;
      end else if (adv) begin
         q3_ff <= q3_in;
      end
   end

   // stage 4: partial products of B*B and |A|*C
   itsolv_pkg::quad_type q4_ff;
   logic [PW-1:0] pbhh_ff, pbhl_ff, pbll_ff;
   logic [PW-1:0] pahch_ff, pahcl_ff, palch_ff, palcl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q4_ff.vld <= 1'b0;
      end else if (adv) begin
         q4_ff <= q3_ff;
         pbhh_ff <= q3_ff.b_abs[PW-1:HW] * q3_ff.b_abs[PW-1:HW];
         pbhl_ff <= q3_ff.b_abs[PW-1:HW] * q3_ff.b_abs[HW-1:0];
         pbll_ff <= q3_ff.b_abs[HW-1:0] * q3_ff.b_abs[HW-1:0];
         pahch_ff <= q3_ff.a_abs[PW-1:HW] * q3_ff.c[PW-1:HW];
         pahcl_ff <= q3_ff.a_abs[PW-1:HW] * q3_ff.c[HW-1:0];
         palch_ff <= q3_ff.a_abs[HW-1:0] * q3_ff.c[PW-1:HW];
         palcl_ff <= q3_ff.a_abs[HW-1:0] * q3_ff.c[HW-1:0];
      end
   end

   // stage 5: combine partial products
   itsolv_pkg::quad_type q5_ff;
   logic [WW-1:0] bsq5_ff;
   logic [WW-1:0] ac5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q5_ff.vld <= 1'b0;
      end else if (adv) begin
         q5_ff <= q4_ff;
         bsq5_ff <= (WW'(pbhh_ff) << (2 * HW)) + (WW'(pbhl_ff) << (HW + 1)) + WW'(pbll_ff);
         ac5_ff <= (WW'(pahch_ff) << (2 * HW))
                   + ((WW'(pahcl_ff) + WW'(palch_ff)) << HW) + WW'(palcl_ff);
      end
   end

   // stage 6 onward: discriminant and bit-per-stage square root
   itsolv_pkg::sq_type sq_ff [0:SQS];
   itsolv_pkg::sq_type sq_in [0:SQS];

   always_comb begin
      sq_in[0].q = q5_ff;
      sq_in[0].root = '0;
      sq_in[0].rem = '0;
      sq_in[0].real_ok = 1'b1;
      if (q5_ff.a_neg) begin
         sq_in[0].disc = DW'(bsq5_ff) + DW'(ac5_ff);
      end else if (bsq5_ff < ac5_ff) begin
         sq_in[0].real_ok = 1'b0;
         sq_in[0].disc = '0;
      end else begin
         sq_in[0].disc = DW'(bsq5_ff) - DW'(ac5_ff);
      end
   end

   for (genvar k = 0; k < SQS; k++) begin : g_sqrt
      logic [SRW-1:0] remt;
      logic [SRW-1:0] trial;

      always_comb begin
         remt = {sq_ff[k].rem[SRW-3:0], sq_ff[k].disc[DW-1-2*k -: 2]};
         trial = {{(SRW - RW - 2){1'b0}}, sq_ff[k].root, 2'b01};
         sq_in[k+1] = sq_ff[k];
         if (remt >= trial) begin
            sq_in[k+1].rem = remt - trial;
            sq_in[k+1].root = {sq_ff[k].root[RW-2:0], 1'b1};
         end else begin
            sq_in[k+1].rem = remt;
            sq_in[k+1].root = {sq_ff[k].root[RW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQS; k++) begin
            sq_ff[k].q.vld <= 1'b0;
         end
      end else if (adv) begin
         sq_ff <= sq_in;
      end
   end

   // root selection, then long division
   itsolv_pkg::dv_type dv_ff [0:DVS+1];
   itsolv_pkg::dv_type dv_in [0:DVS+1];
   itsolv_pkg::quad_type qf;
   logic signed [NW-1:0] nb, rs, n0, n1, nsel, nmag;
   logic ok0, ok1;

   always_comb begin
      qf = sq_ff[SQS].q;
      nb = -(NW'(qf.b));
      rs = $signed({{(NW - RW){1'b0}}, sq_ff[SQS].root});
      n0 = nb + rs;
      n1 = nb - rs;
      ok0 = (n0 != '0) && (n0[NW-1] == qf.a_neg);
      ok1 = (n1 != '0) && (n1[NW-1] == qf.a_neg);
      if (qf.a_neg) begin
         nsel = ok0 ? n0 : n1;
      end else begin
         nsel = ok1 ? n1 : n0;
      end
      nmag = nsel[NW-1] ? -nsel : nsel;
      dv_in[0].vld = qf.vld;
      dv_in[0].geo = qf.geo;
      dv_in[0].sat = 1'b0;
      dv_in[0].rem = '0;
      dv_in[0].quo = '0;
      if (qf.a_zero) begin
         dv_in[0].hit = qf.b[BW-1] && (qf.c != '0);
         dv_in[0].num = {{(UW - PW){1'b0}}, qf.c};
         dv_in[0].den = {{(UW - PW - 1){1'b0}}, qf.b_abs, 1'b0};
      end else begin
         dv_in[0].hit = sq_ff[SQS].real_ok && (ok0 || ok1);
         dv_in[0].num = nmag[UW-1:0];
         dv_in[0].den = {{(UW - PW){1'b0}}, qf.a_abs};
      end
   end

   always_comb begin
      dv_in[1] = dv_ff[0];
      dv_in[1].sat = {{IB{1'b0}}, dv_ff[0].num} >= {dv_ff[0].den, {IB{1'b0}}};
      dv_in[1].rem = {{IB{1'b0}}, dv_ff[0].num[UW-1:IB]};
      dv_in[1].quo = '0;
   end

   for (genvar k = 0; k < DVS; k++) begin : g_div
      logic          nbit;
      logic [UW:0]   remt;
      logic [UW:0]   dext;

      if (k < IB) begin : g_feed
         assign nbit = dv_ff[k+1].num[IB-1-k];
      end else begin : g_zero
         assign nbit = 1'b0;
      end

      always_comb begin
         remt = {dv_ff[k+1].rem, nbit};
         dext = {1'b0, dv_ff[k+1].den};
         dv_in[k+2] = dv_ff[k+1];
         if (remt >= dext) begin
            dv_in[k+2].rem = UW'(remt - dext);
            dv_in[k+2].quo = {dv_ff[k+1].quo[TW-2:0], 1'b1};
         end else begin
            dv_in[k+2].rem = remt[UW-1:0];
            dv_in[k+2].quo = {dv_ff[k+1].quo[TW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DVS + 1; k++) begin
            dv_ff[k].vld <= 1'b0;
         end
      end else if (adv) begin
         dv_ff <= dv_in;
      end
   end

   // time select and velocity scaling
   logic                    vld9_ff, hit9_ff, sat9_ff;
   itsolv_pkg::geo_type     geo9_ff;
   logic [TW-1:0]           t9_ff;
   logic signed [PTW-1:0]   p9_ff [3];
   logic [TW-1:0]           tsel;

   assign tsel = dv_ff[DVS+1].sat ? itsolv_pkg::TIME_MAX : dv_ff[DVS+1].quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld9_ff <= 1'b0;
      end else if (adv) begin
         vld9_ff <= dv_ff[DVS+1].vld;
         hit9_ff <= dv_ff[DVS+1].hit;
         sat9_ff <= dv_ff[DVS+1].sat;
         geo9_ff <= dv_ff[DVS+1].geo;
         t9_ff <= tsel;
         for (int i = 0; i < 3; i++) begin
            p9_ff[i] <= $signed(dv_ff[DVS+1].geo.v[i]) * $signed({1'b0, tsel});
         end
      end
   end

   // aim point, clamp, response register
   logic signed [SUM_WIDTH-1:0]  aim_sum [3];
   logic [COORD_WIDTH-1:0]       aim_in [3];
   logic [2:0]                   aim_clip;
   logic                         hit_ff, clipped_ff;
   logic [TW-1:0]                time_ff;
   logic [COORD_WIDTH-1:0]       aim_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         aim_sum[i] = SUM_WIDTH'($signed(geo9_ff.d[i]))
                      + SUM_WIDTH'($signed(p9_ff[i][PTW-1:FB]));
         aim_clip[i] = 1'b0;
         aim_in[i] = aim_sum[i][COORD_WIDTH-1:0];
         if (aim_sum[i] > AIM_HI) begin
            aim_in[i] = AIM_HI[COORD_WIDTH-1:0];
            aim_clip[i] = 1'b1;
         end else if (aim_sum[i] < AIM_LO) begin
            aim_in[i] = AIM_LO[COORD_WIDTH-1:0];
            aim_clip[i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld9_ff;
         hit_ff <= hit9_ff;
         time_ff <= hit9_ff ? t9_ff : '0;
         clipped_ff <= hit9_ff && (sat9_ff || (aim_clip != '0));
         for (int i = 0; i < 3; i++) begin
            aim_ff[i] <= hit9_ff ? aim_in[i] : '0;
         end
      end
   end

   assign rsp_bus.valid = out_vld_ff;
   assign rsp_bus.hit_valid = hit_ff;
   assign rsp_bus.hit_time = time_ff;
   assign rsp_bus.aim_x = aim_ff[0];
   assign rsp_bus.aim_y = aim_ff[1];
   assign rsp_bus.aim_z = aim_ff[2];
   assign rsp_bus.clipped = clipped_ff;

endmodule
`default_nettype wire

/* verif/itsolv_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module itsolv_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   itsolv_req_if                                     req,
   itsolv_rsp_if                                     rsp,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic                                 pready,
   input  wire logic [itsolv_pkg::ADDR_WIDTH-1:0]    paddr,
   input  wire logic [itsolv_pkg::DATA_WIDTH-1:0]    pwdata,
   output int                                        fail_count,
   output int                                        pending
);

   localparam int AW = itsolv_pkg::ADDR_WIDTH;
   localparam int TW = itsolv_pkg::TIME_WIDTH;
   localparam int SW = itsolv_pkg::SPEED_WIDTH;
   localparam logic [AW-1:0] ADDR_SPEED = AW'(4 * itsolv_pkg::REG_SPEED);
   localparam longint AIM_HI = (64'sd1 <<< 23) - 1;
   localparam longint AIM_LO = -(64'sd1 <<< 23);

   typedef struct packed {
      logic                          hit_valid;
      logic [TW-1:0]                 hit_time;
      logic signed [2:0][23:0]       aim;
      logic                          clipped;
   } intercept_type;

   intercept_type          intercept_q[$];
   logic [SW-1:0]          speed;

   function automatic logic [TW-1:0] time_div(input logic [127:0] num, den,
                                               output logic sat);
      sat = 0;
      if (num / den > 255) begin
         sat = 1;
         return itsolv_pkg::TIME_MAX;
      end
      return TW'((num << 16) / den);
   endfunction

   function automatic logic [63:0] isqrt(input logic [127:0] val);
      logic [63:0] root, trial;
      root = 0;
      for (int i = 63; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if ({64'd0, trial} * {64'd0, trial} <= val) root = trial;
      end
      return root;
   endfunction

   function automatic intercept_type solve_intercept(input logic signed [23:0] pos[3],
                                                     input logic signed [23:0] vel[3],
                                                     input logic [SW-1:0] spd);
      intercept_type res;
      longint dd[3], vv[3], a, b, root, n[2], prod, aim;
      longint unsigned c, vsq;
      logic [127:0] b2, ac, disc;
      logic [TW-1:0] t, q;
      logic ok, sat, s, has_root;
      ok = 0; sat = 0; t = 0; b = 0; c = 0; vsq = 0; has_root = 1;
      res = '0;
      for (int i = 0; i < 3; i++) begin
         dd[i] = longint'(pos[i]);
         vv[i] = longint'(vel[i]);
         vsq += vv[i] * vv[i];
         c += dd[i] * dd[i];
         b += dd[i] * vv[i];
      end
      a = longint'(vsq) - longint'({41'd0, spd}) * longint'({41'd0, spd});
      if (a == 0) begin
         if (b < 0 && c > 0) begin
            ok = 1;
            t = time_div(128'(c), 128'(2 * (-b)), sat);
         end
      end else begin
         b2 = 128'(b < 0 ? -b : b) * 128'(b < 0 ? -b : b);
         ac = 128'(a < 0 ? -a : a) * 128'(c);
         if (a < 0) disc = b2 + ac;
         else if (b2 < ac) has_root = 0;
         else disc = b2 - ac;
         if (has_root) begin
            root = longint'(isqrt(disc));
            n[0] = -b + root;
            n[1] = -b - root;
            for (int i = 0; i < 2; i++) begin
               if (n[i] != 0 && ((n[i] > 0) == (a > 0))) begin
                  q = time_div(128'(n[i] < 0 ? -n[i] : n[i]), 128'(a < 0 ? -a : a), s);
                  if (!ok || q < t) begin
                     t = q;
                     sat = s;
                  end
                  ok = 1;
               end
            end
         end
      end
      if (ok) begin
         res.hit_valid = 1;
         res.hit_time = t;
         for (int i = 0; i < 3; i++) begin
            prod = vv[i] * longint'({40'd0, t});
            aim = dd[i] + (prod >>> 16);
            if (aim > AIM_HI) begin aim = AIM_HI; sat = 1; end
            if (aim < AIM_LO) begin aim = AIM_LO; sat = 1; end
            res.aim[i] = aim[23:0];
         end
         res.clipped = sat;
      end
      return res;
   endfunction

   task automatic compare(input string name, input longint want, got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   assign pending = intercept_q.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      logic signed [23:0] pos[3], vel[3];
      intercept_type want, got;
      if (reset) begin
         speed = itsolv_pkg::SPEED_RESET;
         intercept_q.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == ADDR_SPEED)
            speed = pwdata[SW-1:0];
         if (req.valid && req.ready) begin
            pos = '{req.rel_x, req.rel_y, req.rel_z};
            vel = '{req.vel_x, req.vel_y, req.vel_z};
            intercept_q.insert(intercept_q.size(), solve_intercept(pos, vel, speed));
         end
         if (rsp.valid && rsp.ready) begin
            got.hit_valid = rsp.hit_valid;
            got.hit_time = rsp.hit_time;
            got.aim = '{rsp.aim_z, rsp.aim_y, rsp.aim_x};
            got.clipped = rsp.clipped;
            if (intercept_q.size() == 0) begin
               $display("%0t: unexpected transaction, actual %p", $time, got);
               fail_count++;
            end else begin
               want = intercept_q.pop_front();
               compare("hit_valid", want.hit_valid, got.hit_valid);
               compare("hit_time", want.hit_time, got.hit_time);
               compare("aim_x", want.aim[0], got.aim[0]);
               compare("aim_y", want.aim[1], got.aim[1]);
               compare("aim_z", want.aim[2], got.aim[2]);
               compare("clipped", want.clipped, got.clipped);
            end
         end
      end
   end
endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

   localparam int AW = itsolv_pkg::ADDR_WIDTH;
   localparam int DW = itsolv_pkg::DATA_WIDTH;
   localparam int SW = itsolv_pkg::SPEED_WIDTH;
   localparam logic [AW-1:0] ADDR_SPEED = AW'(4 * itsolv_pkg::REG_SPEED);

   logic                   clock = 0;
   logic                   reset;
   logic                   psel, penable, pwrite, pready;
   logic [AW-1:0]          paddr;
   logic [DW-1:0]          pwdata, prdata;
   logic                   steady;
   int                     fail_count, pending;

   itsolv_req_if req_bus ();
   itsolv_rsp_if rsp_bus ();

   intercept_time_solver i_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   itsolv_checker i_checker (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
   );

   always #4 clock = ~clock;

   initial begin
      #5ms;
      $display("** intercept_time_solver: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 0;
      else rsp_bus.ready <= steady || ($urandom_range(99) >= 38);
   end

   task automatic write_speed(input logic [SW-1:0] spd);
      psel <= 1; pwrite <= 1; penable <= 0; paddr <= ADDR_SPEED;
      pwdata <= DW'(spd);
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending != 0) @(posedge clock);
   endtask

   task automatic send(input logic signed [23:0] rx, ry, rz, vx, vy, vz);
      while (!steady && $urandom_range(99) < 38) begin
         req_bus.valid <= 0;
         @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.rel_x <= rx; req_bus.rel_y <= ry; req_bus.rel_z <= rz;
      req_bus.vel_x <= vx; req_bus.vel_y <= vy; req_bus.vel_z <= vz;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic hold();
      req_bus.valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic signed [23:0] scaled_coord();
      logic signed [23:0] raw;
      raw = 24'($urandom());
      return raw >>> $urandom_range(23, 0);
   endfunction

   task automatic random_phase(input logic [SW-1:0] spd, input int count);
      logic signed [23:0] f[6];
      int axis;
      hold();
      drain();
      write_speed(spd);
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(3))
            0: for (int i = 0; i < 6; i++) f[i] = 24'($urandom());
            1, 2: for (int i = 0; i < 6; i++) f[i] = scaled_coord();
            default: begin
               for (int i = 0; i < 6; i++) f[i] = (i < 3) ? scaled_coord() : 24'sd0;
               axis = $urandom_range(2);
               f[3 + axis] = $urandom_range(1) ? 24'(spd) : -24'(spd);
            end
         endcase
         send(f[0], f[1], f[2], f[3], f[4], f[5]);
      end
      hold();
   endtask

   initial begin
      reset <= 1;
      psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
      req_bus.valid <= 0;
      req_bus.rel_x <= '0; req_bus.rel_y <= '0; req_bus.rel_z <= '0;
      req_bus.vel_x <= '0; req_bus.vel_y <= '0; req_bus.vel_z <= '0;
      steady <= 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(0, 0, 0, 0, 0, 0);
      send(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
      send(-24'sh800000, -24'sh800000, -24'sh800000,
           -24'sh800000, -24'sh800000, -24'sh800000);
      send(2560, 0, 0, 0, 0, 0);
      send(24'sh7FFFFF, 0, 0, 0, 0, 0);
      send(-24'sh800000, 24'sh7FFFFF, 0, 24'sh7FFFFF, -24'sh800000, 0);
      hold();
      drain();
      write_speed(256);
      send(-2560, 0, 0, 256, 0, 0);
      send(2560, 0, 0, 256, 0, 0);
      send(0, 2560, 0, 256, 0, 0);
      send(0, 0, 0, 0, 0, -256);
      hold();
      drain();
      write_speed(1);
      send(24'sh7FFFFF, 0, 0, 0, 0, 0);
      send(0, 2560, 0, 512, 0, 0);
      send(-24'sh800000, 0, 0, 24'sh7FFFFF, 24'sh7FFFFF, 0);
      send(24'sh7FFFFF, 0, 0, -24'sh800000, 1, 0);
      hold();
      drain();
      write_speed(23'h7FFFFF);
      send(1, 0, 0, 0, 0, 0);
      send(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
      send(0, 0, -1, 0, 0, 0);
      hold();
      drain();
      write_speed(0);
      send(2560, 0, 0, -256, 0, 0);
      send(2560, 0, 0, 256, 0, 0);
      send(0, 0, 0, 0, 0, 0);

      random_phase(itsolv_pkg::SPEED_RESET, 200);
      random_phase(23'h7FFFFF, 180);
      steady <= 1;
      random_phase(SW'($urandom_range(23'h7FFFFF)), 200);
      steady <= 0;
      random_phase(0, 150);
      random_phase(SW'($urandom_range(4095)), 200);
      random_phase(SW'($urandom_range(23'h7FFFFF)), 200);

      drain();
      repeat (120) @(posedge clock);
      if (fail_count == 0) begin
         $display("** intercept_time_solver: PASSED **");
      end else begin
         $display("** intercept_time_solver: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire
